FILE: src/fpdn_pkg.sv
// ----------------------------------------------------------------------------
// fpdn_pkg
// types and constants shared by the dense neuron multiply-accumulate
// ----------------------------------------------------------------------------
package fpdn_pkg;

    localparam int unsigned DATA_W      = 16;
    localparam int unsigned PSHIFT_W    = 5;
    localparam int unsigned BSHIFT_W    = 4;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 5;

    // saturation bounds of the 16-bit signed range
    localparam logic signed [2*DATA_W-1:0] Q16_MAX = 32'sd32767;
    localparam logic signed [2*DATA_W-1:0] Q16_MIN = -32'sd32768;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRODUCT_SHIFT   = 2'd0,
        CFG_BIAS_SHIFT      = 2'd1,
        CFG_ACTIVATION_MODE = 2'd2
    } cfg_index_t;

    // activation codes
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_RELU   = 1'b1;

    // product stage contents
    typedef struct packed {
        logic signed [DATA_W-1:0] term;
        logic signed [DATA_W-1:0] bias;
        logic                     last_term;
        logic                     last_neuron;
    } stage_t;

endpackage

FILE: src/fixed_point_dense_neuron_mac.sv
// ----------------------------------------------------------------------------
// fixed_point_dense_neuron_mac
// streaming multiply-accumulate for one dense-layer neuron, signed 16 bit
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid/in_ready) carries one activation/weight pair per
//   transaction, plus the neuron bias and the last_term/last_neuron marks.
//   output channel (out_valid/out_ready) carries one finished neuron value
//   per neuron, produced by the transaction whose last_term is set.
//   configuration channel (cfg_valid/cfg_ready) writes product_shift,
//   bias_shift and activation_mode; cfg_ready is always high, and writes must
//   be made only while the block is idle; the block does not enforce it.
// Timing:
//   two register stages: the product stage (multiply, clamp, shift) and the
//   accumulate stage, whose final sum lands in the output register. A final
//   term passes the product stage register, then the output register. One
//   transaction is accepted per cycle unless stalled; acc_reg feeds the adder.
// Stalls:
//   non-final terms are folded into the accumulator even while a result waits
//   in the output register; only a final term blocks until that register is
//   free, and the input then stalls once the product stage is full.
// Reset:
//   rst_n clears the accumulator, valid flags and configuration to zero.
// ----------------------------------------------------------------------------
module fixed_point_dense_neuron_mac
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [fpdn_pkg::DATA_W-1:0]    activation_in,
    input  logic signed [fpdn_pkg::DATA_W-1:0]    weight_in,
    input  logic signed [fpdn_pkg::DATA_W-1:0]    bias_in,
    input  logic                                  last_term,
    input  logic                                  last_neuron,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fpdn_pkg::DATA_W-1:0]    neuron_out,
    output logic                                  layer_done,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fpdn_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fpdn_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // configuration registers
    logic [fpdn_pkg::PSHIFT_W-1:0] product_shift_reg;
    logic [fpdn_pkg::BSHIFT_W-1:0] bias_shift_reg;
    logic                          activation_mode_reg;

    // product stage
    fpdn_pkg::stage_t              stage_reg;
    fpdn_pkg::stage_t              stage_next;
    logic                          stage_vld_reg;

    // accumulate stage and output register
    logic signed [fpdn_pkg::DATA_W-1:0] acc_reg;
    logic signed [fpdn_pkg::DATA_W-1:0] acc_next;
    logic signed [fpdn_pkg::DATA_W-1:0] neuron_out_reg;
    logic signed [fpdn_pkg::DATA_W-1:0] neuron_out_next;
    logic                               layer_done_reg;
    logic                               out_vld_reg;

    logic signed [2*fpdn_pkg::DATA_W-1:0] product;
    logic signed [fpdn_pkg::DATA_W-1:0]   clamped;
    logic signed [fpdn_pkg::DATA_W-1:0]   sum;
    logic signed [fpdn_pkg::DATA_W-1:0]   bias_scaled;
    logic signed [fpdn_pkg::DATA_W-1:0]   total;
    logic                                 out_free;
    logic                                 acc_take;
    logic                                 in_take;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    // output register can accept a new result this cycle
    assign out_free  = !out_vld_reg || out_ready;
    // a non-final term never needs the output register
    assign acc_take  = stage_vld_reg && (!stage_reg.last_term || out_free);
    assign in_ready  = !stage_vld_reg || acc_take;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // configuration writes, unknown indexes ignored
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            product_shift_reg   <= '0;
            bias_shift_reg      <= '0;
            activation_mode_reg <= fpdn_pkg::MODE_LINEAR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (fpdn_pkg::cfg_index_t'(cfg_index))
                fpdn_pkg::CFG_PRODUCT_SHIFT:
                    product_shift_reg <= cfg_data[fpdn_pkg::PSHIFT_W-1:0];
                fpdn_pkg::CFG_BIAS_SHIFT:
                    bias_shift_reg <= cfg_data[fpdn_pkg::BSHIFT_W-1:0];
                fpdn_pkg::CFG_ACTIVATION_MODE:
                    activation_mode_reg <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // product stage: multiply, saturate to 16 bits, arithmetic shift
    // ------------------------------------------------------------------
    always_comb
    begin
        product = activation_in * weight_in;
        if (product > fpdn_pkg::Q16_MAX)
            clamped = fpdn_pkg::Q16_MAX[fpdn_pkg::DATA_W-1:0];
        else if (product < fpdn_pkg::Q16_MIN)
            clamped = fpdn_pkg::Q16_MIN[fpdn_pkg::DATA_W-1:0];
        else
            clamped = product[fpdn_pkg::DATA_W-1:0];

        // shifts of 16 and up fill with the sign, as the shifter does
        stage_next.term        = clamped >>> product_shift_reg;
        stage_next.bias        = bias_in;
        stage_next.last_term   = last_term;
        stage_next.last_neuron = last_neuron;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_vld_reg <= 1'b0;
        else if (in_ready)
            stage_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            stage_reg <= stage_next;
    end

    // ------------------------------------------------------------------
    // accumulate stage: wrapping add, bias on the last term, optional relu
    // ------------------------------------------------------------------
    always_comb
    begin
        sum         = acc_reg + stage_reg.term;
        bias_scaled = stage_reg.bias >>> bias_shift_reg;
        total       = sum + bias_scaled;

        if (activation_mode_reg == fpdn_pkg::MODE_RELU && total[fpdn_pkg::DATA_W-1])
            neuron_out_next = '0;
        else
            neuron_out_next = total;

        // neuron finished: clear for the next one
        if (stage_reg.last_term)
            acc_next = '0;
        else
            acc_next = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (acc_take)
                acc_reg <= acc_next;

            if (acc_take && stage_reg.last_term)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_take && stage_reg.last_term)
        begin
            neuron_out_reg <= neuron_out_next;
            layer_done_reg <= stage_reg.last_neuron;
        end
    end

    assign out_valid  = out_vld_reg;
    assign neuron_out = neuron_out_reg;
    assign layer_done = layer_done_reg;

endmodule

FILE: dv/tb_fixed_point_dense_neuron_mac.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_dense_neuron_mac
// self-checking bench for the dense neuron multiply-accumulate: directed
// corner terms, then randomized neurons under several register settings,
// with random idle and stall bursts on both channels
// ----------------------------------------------------------------------------
module tb_fixed_point_dense_neuron_mac;

    // cycles to let non-final terms leave the two register stages
    localparam int PIPE_FLUSH  = 6;
    // generous ceiling on the whole run, in time units
    localparam int RUN_LIMIT   = 5_000_000;
    // lower bound on random terms per register setting
    localparam int PHASE_TERMS = 225;
    localparam int PHASES      = 6;

    // index past the register list, writes to it must be ignored
    localparam logic [fpdn_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic                                       clk           = 1'b0;
    logic                                       rst_n         = 1'b0;

    logic                                       in_valid      = 1'b0;
    logic                                       in_ready;
    logic signed [fpdn_pkg::DATA_W-1:0]         activation_in = '0;
    logic signed [fpdn_pkg::DATA_W-1:0]         weight_in     = '0;
    logic signed [fpdn_pkg::DATA_W-1:0]         bias_in       = '0;
    logic                                       last_term     = 1'b0;
    logic                                       last_neuron   = 1'b0;

    logic                                       out_valid;
    logic                                       out_ready     = 1'b1;
    logic signed [fpdn_pkg::DATA_W-1:0]         neuron_out;
    logic                                       layer_done;

    logic                                       cfg_valid     = 1'b0;
    logic                                       cfg_ready;
    logic [fpdn_pkg::CFG_INDEX_W-1:0]           cfg_index     = '0;
    logic [fpdn_pkg::CFG_DATA_W-1:0]            cfg_data      = '0;

    // set for the closing stretch, turns off idling on both sides
    bit                                         quiet         = 1'b0;

    // one finished neuron as it should leave the block
    typedef struct packed {
        logic signed [fpdn_pkg::DATA_W-1:0] value;
        logic                               layer_done;
    } neuron_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: mirrors the accumulator and registers, queues finished
    // neuron values in order and compares them against the output channel
    // ------------------------------------------------------------------------
    class neuron_scoreboard;
        logic [fpdn_pkg::PSHIFT_W-1:0]      product_shift;
        logic [fpdn_pkg::BSHIFT_W-1:0]      bias_shift;
        logic                               act_mode;
        logic signed [fpdn_pkg::DATA_W-1:0] running_sum;
        neuron_result_t                     finished_q[$];
        int                                 errors;

        function new();
            product_shift = '0;
            bias_shift    = '0;
            act_mode      = fpdn_pkg::MODE_LINEAR;
            running_sum   = '0;
            errors        = 0;
        endfunction

        // register write, data masked to the register width
        function void write_reg(logic [fpdn_pkg::CFG_INDEX_W-1:0] idx,
                                logic [fpdn_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                fpdn_pkg::CFG_PRODUCT_SHIFT:
                    product_shift = data[fpdn_pkg::PSHIFT_W-1:0];
                fpdn_pkg::CFG_BIAS_SHIFT:
                    bias_shift    = data[fpdn_pkg::BSHIFT_W-1:0];
                fpdn_pkg::CFG_ACTIVATION_MODE:
                    act_mode      = data[0];
                default:
                    ;
            endcase
        endfunction

        // fold one accepted input transaction into the neuron
        function void note_term(logic signed [fpdn_pkg::DATA_W-1:0] act,
                                logic signed [fpdn_pkg::DATA_W-1:0] wt,
                                logic signed [fpdn_pkg::DATA_W-1:0] bias,
                                logic lt, logic ln);
            logic signed [2*fpdn_pkg::DATA_W-1:0] prod;
            logic signed [fpdn_pkg::DATA_W-1:0]   total;
            neuron_result_t                       res;
            prod = act * wt;
            if (prod > fpdn_pkg::Q16_MAX)
                prod = fpdn_pkg::Q16_MAX;
            else if (prod < fpdn_pkg::Q16_MIN)
                prod = fpdn_pkg::Q16_MIN;
            prod = prod >>> product_shift;
            // accumulator wraps at 16 bits
            running_sum = running_sum + prod[fpdn_pkg::DATA_W-1:0];
            if (!lt)
                return;
            total = running_sum + (bias >>> bias_shift);
            if (act_mode == fpdn_pkg::MODE_RELU && total < 0)
                total = '0;
            res.value      = total;
            res.layer_done = ln;
            finished_q.push_back(res);
            running_sum = '0;
        endfunction

        function void check_result(logic signed [fpdn_pkg::DATA_W-1:0] value, logic done);
            neuron_result_t want;
            if (finished_q.size() == 0)
            begin
                $display("%0t: unexpected neuron output expected=none actual=%0d/%0b",
                         $time, value, done);
                errors++;
                return;
            end
            want = finished_q.pop_front();
            if (value !== want.value)
            begin
                $display("%0t: neuron_out mismatch expected=%0d actual=%0d",
                         $time, want.value, value);
                errors++;
            end
            if (done !== want.layer_done)
            begin
                $display("%0t: layer_done mismatch expected=%0b actual=%0b",
                         $time, want.layer_done, done);
                errors++;
            end
        endfunction

        function int pending();
            return finished_q.size();
        endfunction
    endclass

    neuron_scoreboard sb = new();

    fixed_point_dense_neuron_mac dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .activation_in (activation_in),
        .weight_in     (weight_in),
        .bias_in       (bias_in),
        .last_term     (last_term),
        .last_neuron   (last_neuron),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .neuron_out    (neuron_out),
        .layer_done    (layer_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 10 time unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // transaction monitor: every handshake is seen at the edge that completes
    // it, with pre-edge values, so driver and block updates never race it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_term(activation_in, weight_in, bias_in, last_term, last_neuron);
            if (out_valid && out_ready)
                sb.check_result(neuron_out, layer_done);
        end
    end

    // receiver: random stall bursts, none in the closing stretch
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // hard stop if the block hangs
    initial
    begin
        #(RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // operand mix: extremes, small values around zero and full-range noise
    function automatic logic signed [fpdn_pkg::DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(0, 64) - 32);
            3:       return $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
            4:       return 16'($urandom_range(0, 400) - 200);
            default: return 16'($urandom());
        endcase
    endfunction

    // one register write transaction, valid stays up for back-to-back writes
    task automatic write_reg(logic [fpdn_pkg::CFG_INDEX_W-1:0] idx,
                             logic [fpdn_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // full register setting, optionally with a write to the unused index
    task automatic program_regs(logic [fpdn_pkg::CFG_DATA_W-1:0] pshift,
                                logic [fpdn_pkg::CFG_DATA_W-1:0] bshift,
                                logic [fpdn_pkg::CFG_DATA_W-1:0] mode, bit poke_unmapped);
        write_reg(fpdn_pkg::CFG_PRODUCT_SHIFT, pshift);
        if (poke_unmapped)
            write_reg(CFG_UNMAPPED, fpdn_pkg::CFG_DATA_W'($urandom()));
        write_reg(fpdn_pkg::CFG_BIAS_SHIFT, bshift);
        write_reg(fpdn_pkg::CFG_ACTIVATION_MODE, mode);
        cfg_valid <= 1'b0;
    endtask

    // one input transaction, preceded by an occasional idle burst
    task automatic send_term(logic signed [fpdn_pkg::DATA_W-1:0] act,
                             logic signed [fpdn_pkg::DATA_W-1:0] wt,
                             logic signed [fpdn_pkg::DATA_W-1:0] bias, logic lt, logic ln);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        activation_in <= act;
        weight_in     <= wt;
        bias_in       <= bias;
        last_term     <= lt;
        last_neuron   <= ln;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop sending until every finished neuron has come out and the
    // non-final terms behind it have cleared the pipeline; the first edge
    // lets the monitor log the last accepted transaction
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_FLUSH) @(posedge clk);
    endtask

    // random neuron; last_neuron is also toggled on inner terms, where it
    // has no effect
    task automatic send_neuron(int len);
        for (int i = 0; i < len; i++)
        begin
            if (i == len - 1)
                send_term(pick_operand(), pick_operand(), pick_operand(), 1'b1,
                          $urandom_range(0, 3) == 0);
            else
                send_term(pick_operand(), pick_operand(), pick_operand(), 1'b0,
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int                              sent;
        int                              len;
        logic [fpdn_pkg::CFG_DATA_W-1:0] pshift;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: raw product, unshifted bias, linear
        send_term(16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b1, 1'b0);  // product clamps high
        send_term(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b1);  // clamps high, min bias
        send_term(16'sh8000, 16'sh7FFF, 16'sh0000, 1'b0, 1'b0);  // clamps low
        send_term(16'sh8000, 16'sh0001, 16'sh0000, 1'b0, 1'b1);  // sum wraps to zero
        send_term(16'sh0000, 16'sh0000, 16'sh7FFF, 1'b1, 1'b1);  // max bias only
        send_term(16'sh0001, 16'sh7FFF, 16'sh0000, 1'b0, 1'b0);
        send_term(16'sh0001, 16'sh0001, 16'sh0000, 1'b1, 1'b0);  // positive overflow wraps

        // widest shifts with relu: everything collapses to 0 or -1
        settle();
        program_regs(5'd31, 5'd15, 5'(fpdn_pkg::MODE_RELU), 1'b1);
        send_term(-16'sd5, 16'sd7, 16'sh0000, 1'b0, 1'b0);
        send_term(16'sd100, 16'sd100, 16'shFFFF, 1'b1, 1'b0);    // negative clipped by relu
        send_term(16'sd300, 16'sd300, 16'sh7FFF, 1'b1, 1'b1);

        // out-of-width writes: bias shift masks to 15, mode 3 masks to relu
        settle();
        program_regs(5'd15, 5'd31, 5'd3, 1'b1);
        send_term(16'sh8000, 16'sh0001, 16'sh0000, 1'b1, 1'b0);
        send_term(16'sh7FFF, 16'sh0001, 16'sh8000, 1'b1, 1'b1);

        // moderate shifts, relu passes positives and clips negatives
        settle();
        program_regs(5'd4, 5'd2, 5'(fpdn_pkg::MODE_RELU), 1'b0);
        send_term(16'sd1000, 16'sd10, 16'sd400, 1'b1, 1'b0);
        send_term(-16'sd1000, 16'sd10, 16'sd400, 1'b1, 1'b0);

        // mode 2 masks to linear, negative result passes
        settle();
        program_regs(5'd1, 5'd1, 5'd2, 1'b0);
        send_term(-16'sd3, 16'sd1, -16'sd3, 1'b1, 1'b1);

        // randomized neurons under a new register setting per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            if (phase == PHASES - 1)
                quiet = 1'b1;
            case (phase)
                0:       program_regs(5'd0, 5'd0, 5'(fpdn_pkg::MODE_LINEAR), 1'b1);
                1:       program_regs(5'd31, 5'd15, 5'(fpdn_pkg::MODE_RELU), 1'b0);
                default:
                begin
                    // mostly shifts that keep useful bits, sometimes any value
                    pshift = ($urandom_range(0, 3) == 0)
                             ? fpdn_pkg::CFG_DATA_W'($urandom_range(0, 31))
                             : fpdn_pkg::CFG_DATA_W'($urandom_range(0, 16));
                    program_regs(pshift, fpdn_pkg::CFG_DATA_W'($urandom()),
                                 fpdn_pkg::CFG_DATA_W'($urandom()),
                                 1'($urandom_range(0, 1)));
                end
            endcase
            sent = 0;
            while (sent < PHASE_TERMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
                send_neuron(len);
                sent += len;
                // occasional full drain mid-phase
                if (!quiet && $urandom_range(0, 39) == 0)
                    settle();
            end
        end

        // closing drain, the run limit bounds the wait
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_FLUSH * 2) @(posedge clk);

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
